### rtl/core/b64e_pkg.sv
// Package for the Base64 encoder: phase codes, result group type, alphabet lookup.
`default_nettype none

package b64e_pkg;

  // Position of the next byte within its group of three
  typedef enum logic [1:0] {
    PH_FIRST  = 2'd0,
    PH_SECOND = 2'd1,
    PH_THIRD  = 2'd2
  } phase_t;

  localparam int unsigned CharW   = 8;
  localparam int unsigned IdxW    = 6;
  localparam int unsigned MaxChar = 4;
  localparam int unsigned CntW    = $clog2(MaxChar);

  localparam logic [CharW-1:0] PAD_CHAR = 8'h3D;  // '='
  localparam logic [CharW-1:0] CH_UPPER = 8'h41;  // 'A'
  localparam logic [CharW-1:0] CH_LOWER = 8'h61;  // 'a'
  localparam logic [CharW-1:0] CH_DIGIT = 8'h30;  // '0'
  localparam logic [CharW-1:0] CH_PLUS  = 8'h2B;  // '+'
  localparam logic [CharW-1:0] CH_DASH  = 8'h2D;  // '-'

  // Characters caused by one input byte
  typedef struct packed {
    logic [MaxChar-1:0][CharW-1:0] chars;
    logic [CntW-1:0]               last_idx;  // index of the final character
    logic                          msg_end;   // group closes the message
  } group_t;

  // 6-bit index to ASCII: A-Z, a-z, 0-9, '+', '-'
  function automatic logic [CharW-1:0] symbol(input logic [IdxW-1:0] idx);
    logic [CharW-1:0] ext;
    ext = {{(CharW-IdxW){1'b0}}, idx};
    if (idx < 6'd26) begin
      symbol = CH_UPPER + ext;
    end else if (idx < 6'd52) begin
      symbol = CH_LOWER + ext - 8'd26;
    end else if (idx < 6'd62) begin
      symbol = CH_DIGIT + ext - 8'd52;
    end else if (idx == 6'd62) begin
      symbol = CH_PLUS;
    end else begin
      symbol = CH_DASH;
    end
  endfunction

endpackage

`default_nettype wire

### rtl/core/b64e_if.sv
// Handshake channels of the Base64 encoder: byte input and character output.
`default_nettype none

interface b64e_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface b64e_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       run_last;
  logic       message_end;

  modport source (output valid, output out_char, output run_last, output message_end,
                  input ready);
  modport sink   (input valid, input out_char, input run_last, input message_end,
                  output ready);
endinterface

`default_nettype wire

### rtl/core/base64_encoder.sv
// Top level of the streaming Base64 encoder with '=' padding.
//
//   channel  dir  fields                              item
//   in_ch    in   data_byte[7:0], last_byte           one raw byte
//   out_ch   out  out_char[7:0], run_last, message_end one ASCII character
//
// A byte yields one to four characters: one for a non-final first or second byte of a
// group, two for a third byte, four for a final first byte, three for a final second.
// The character stage sends them one per cycle while out_ch.ready holds, setting the rate.
// A byte passes the group register, then the character register, before it is shown.
// The byte stage takes the next byte while the previous group is still sent.
// Reset (synchronous) returns the phase to the start of a group and empties both stages.
// Stalls on out_ch hold the current character and back up into in_ch.ready.
`default_nettype none

module base64_encoder (
  input  logic        clk,
  input  logic        rst,
  b64e_in_if.sink     in_ch,
  b64e_out_if.source  out_ch
);
  import b64e_pkg::*;

  group_t grp;
  logic   grp_valid;
  logic   grp_ready;

  b64e_enc u_enc (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .grp       (grp),
    .grp_valid (grp_valid),
    .grp_ready (grp_ready)
  );

  b64e_ser u_ser (
    .clk       (clk),
    .rst       (rst),
    .grp       (grp),
    .grp_valid (grp_valid),
    .grp_ready (grp_ready),
    .out_ch    (out_ch)
  );

  // Message end only ever lands on the last character of a byte
  a_end_is_run_last: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.message_end) |-> out_ch.run_last)
    else $error("message_end without run_last");

  // A byte is never taken while a held group cannot move on
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready) |-> (!grp_valid || grp_ready))
    else $error("group register overwritten");

  // Nothing is shown right after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_ch.valid)
    else $error("output valid after reset");

endmodule

`default_nettype wire

### rtl/core/b64e_enc.sv
// Byte stage: tracks group phase and leftover bits, registers the characters of one byte.
`default_nettype none

module b64e_enc (
  input  logic            clk,
  input  logic            rst,
  b64e_in_if.sink         in_ch,
  output b64e_pkg::group_t grp,
  output logic            grp_valid,
  input  logic            grp_ready
);
  import b64e_pkg::*;

  phase_t         phase, phase_next;
  logic [IdxW-1:0] pend, pend_next;
  group_t         grp_next;
  logic           accept;
  logic [7:0]     b;

  assign b            = in_ch.data_byte;
  assign in_ch.ready  = !grp_valid || grp_ready;
  assign accept       = in_ch.valid && in_ch.ready;

  // Characters and next state for the byte at the input
  always_comb begin
    grp_next         = '0;
    grp_next.msg_end = in_ch.last_byte;
    phase_next       = phase;
    pend_next        = pend;
    case (phase)
      PH_SECOND: begin
        grp_next.chars[0] = symbol((pend & 6'h30) | {2'b00, b[7:4]});
        pend_next         = {b[3:0], 2'b00};
        if (in_ch.last_byte) begin
          grp_next.chars[1]  = symbol({b[3:0], 2'b00});
          grp_next.chars[2]  = PAD_CHAR;
          grp_next.last_idx  = CntW'(2);
          phase_next         = PH_FIRST;
          pend_next          = '0;
        end else begin
          grp_next.last_idx  = CntW'(0);
          phase_next         = PH_THIRD;
        end
      end
      PH_THIRD: begin
        grp_next.chars[0] = symbol((pend & 6'h3C) | {4'b0000, b[7:6]});
        grp_next.chars[1] = symbol(b[5:0]);
        grp_next.last_idx = CntW'(1);
        phase_next        = PH_FIRST;
        pend_next         = '0;
      end
      default: begin
        // first byte of a group (unused phase code behaves the same)
        grp_next.chars[0] = symbol(b[7:2]);
        pend_next         = {b[1:0], 4'b0000};
        if (in_ch.last_byte) begin
          grp_next.chars[1]  = symbol({b[1:0], 4'b0000});
          grp_next.chars[2]  = PAD_CHAR;
          grp_next.chars[3]  = PAD_CHAR;
          grp_next.last_idx  = CntW'(3);
          phase_next         = PH_FIRST;
          pend_next          = '0;
        end else begin
          grp_next.last_idx  = CntW'(0);
          phase_next         = PH_SECOND;
        end
      end
    endcase
  end

  // State and group register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_FIRST;
      pend      <= '0;
      grp_valid <= 1'b0;
    end else begin
      if (accept) begin
        phase     <= phase_next;
        pend      <= pend_next;
        grp_valid <= 1'b1;
      end else if (grp_ready) begin
        grp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      grp <= grp_next;
    end
  end

endmodule

`default_nettype wire

### rtl/core/b64e_ser.sv
// Character stage: sends the characters of one group, one item per cycle while out_ch.ready is high.
`default_nettype none

module b64e_ser (
  input  logic             clk,
  input  logic             rst,
  input  b64e_pkg::group_t grp,
  input  logic             grp_valid,
  output logic             grp_ready,
  b64e_out_if.source       out_ch
);
  import b64e_pkg::*;

  group_t          cur;
  logic            busy;
  logic [CntW-1:0] idx;
  logic            at_end;
  logic            load;

  assign at_end    = (idx == cur.last_idx);
  assign grp_ready = !busy || (out_ch.ready && at_end);
  assign load      = grp_valid && grp_ready;

  assign out_ch.valid       = busy;
  assign out_ch.out_char    = cur.chars[idx];
  assign out_ch.run_last    = at_end;
  assign out_ch.message_end = at_end && cur.msg_end;

  // Occupancy and character pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else begin
      if (load) begin
        busy <= 1'b1;
        idx  <= '0;
      end else if (busy && out_ch.ready) begin
        if (at_end) begin
          busy <= 1'b0;
        end
        idx <= idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur <= grp;
    end
  end

endmodule

`default_nettype wire
